// File: rtl/fbrc_pkg.sv
// Shared types, constants and the run length table of the Fibonacci run-code decoder.
package fbrc_pkg;

    // Table geometry and header limits.
    localparam int CODE_ENTRIES     = 128;
    localparam int MAX_LENGTH_INDEX = 19;
    localparam int TABLE_DEPTH      = 128;
    localparam int TABLE_AW         = $clog2(TABLE_DEPTH);
    localparam int LI_W             = 5;
    localparam int SYM_W            = 8;
    localparam int CNT_W            = 13;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]       CODE_COUNT_MAX = 8'(CODE_ENTRIES);
    localparam logic [7:0]       LI_MAX_BYTE    = 8'(MAX_LENGTH_INDEX);
    localparam logic [CNT_W-1:0] LITERAL_COUNT  = 13'd1;

    // Header parser phases.
    typedef enum logic [1:0] {
        PH_COUNT  = 2'd0,
        PH_SYMBOL = 2'd1,
        PH_LENGTH = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    // One classified data byte on its way from the front to the back.
    typedef struct packed {
        logic             literal;
        logic             bad;
        logic [SYM_W-1:0] symbol;
        logic [LI_W-1:0]  length_index;
    } item_t;

    // Fibonacci repeat count for a length index; indexes past the top saturate.
    function automatic logic [CNT_W-1:0] fib_count(input logic [LI_W-1:0] li);
        logic [CNT_W-1:0] r;
        case (li)
            5'd0:    r = 13'd1;
            5'd1:    r = 13'd1;
            5'd2:    r = 13'd2;
            5'd3:    r = 13'd3;
            5'd4:    r = 13'd5;
            5'd5:    r = 13'd8;
            5'd6:    r = 13'd13;
            5'd7:    r = 13'd21;
            5'd8:    r = 13'd34;
            5'd9:    r = 13'd55;
            5'd10:   r = 13'd89;
            5'd11:   r = 13'd144;
            5'd12:   r = 13'd233;
            5'd13:   r = 13'd377;
            5'd14:   r = 13'd610;
            5'd15:   r = 13'd987;
            5'd16:   r = 13'd1597;
            5'd17:   r = 13'd2584;
            5'd18:   r = 13'd4181;
            default: r = 13'd6765;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/fbrc_front.sv
// Front end: header parser, code table and table read stage for data bytes.
module fbrc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 block_last,
    output logic                 push_valid,
    input  logic                 push_ready,
    output fbrc_pkg::item_t      push_item
);
    import fbrc_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [7:0]       codes_in_block_reg, codes_in_block_next;
    logic [7:0]       codes_loaded_reg, codes_loaded_next;
    logic             stage_valid_reg, stage_valid_next;
    logic             stage_literal_reg;
    logic             stage_bad_reg;
    logic [7:0]       stage_byte_reg;
    logic [SYM_W-1:0] rd_symbol_reg;
    logic [LI_W-1:0]  rd_li_reg;

    logic [SYM_W-1:0] table_symbol [TABLE_DEPTH];
    logic [LI_W-1:0]  table_length_index [TABLE_DEPTH];

    logic                accept;
    logic                accept_data;
    logic                wr_symbol;
    logic                wr_length;
    logic [TABLE_AW-1:0] slot;
    logic [7:0]          loaded_inc;
    logic [7:0]          li_clamped;

    // The stage takes a new byte when it is empty or its word moves on.
    assign in_ready    = !stage_valid_reg || push_ready;
    assign accept      = in_valid && in_ready;
    assign accept_data = accept && (phase_reg == PH_DATA);
    assign wr_symbol   = accept && (phase_reg == PH_SYMBOL);
    assign wr_length   = accept && (phase_reg == PH_LENGTH);
    assign slot        = codes_loaded_reg[TABLE_AW-1:0];
    assign loaded_inc  = codes_loaded_reg + 8'd1;
    assign li_clamped  = (in_byte > LI_MAX_BYTE) ? LI_MAX_BYTE : in_byte;

    // Header parser next state.
    always_comb
    begin
        phase_next          = phase_reg;
        codes_in_block_next = codes_in_block_reg;
        codes_loaded_next   = codes_loaded_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_COUNT:
                begin
                    codes_in_block_next = (in_byte > CODE_COUNT_MAX) ? CODE_COUNT_MAX : in_byte;
                    codes_loaded_next   = 8'd0;
                    phase_next          = (in_byte == 8'd0) ? PH_DATA : PH_SYMBOL;
                end
                PH_SYMBOL:
                begin
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    codes_loaded_next = loaded_inc;
                    phase_next = (loaded_inc >= codes_in_block_reg) ? PH_DATA : PH_SYMBOL;
                end
                default:
                begin
                    phase_next = PH_DATA;
                end
            endcase
            if (block_last)
            begin
                phase_next = PH_COUNT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_COUNT;
            codes_in_block_reg <= 8'd0;
            codes_loaded_reg   <= 8'd0;
        end
        else
        begin
            phase_reg          <= phase_next;
            codes_in_block_reg <= codes_in_block_next;
            codes_loaded_reg   <= codes_loaded_next;
        end
    end

    // Code table: written while the header loads, read once per data byte.
    always_ff @(posedge clk)
    begin
        if (wr_symbol)
        begin
            table_symbol[slot] <= in_byte;
        end
        if (wr_length)
        begin
            table_length_index[slot] <= li_clamped[LI_W-1:0];
        end
        if (accept_data)
        begin
            rd_symbol_reg <= table_symbol[in_byte[TABLE_AW-1:0]];
            rd_li_reg     <= table_length_index[in_byte[TABLE_AW-1:0]];
        end
    end

    // Classification of a data byte, held next to the table read data.
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept_data)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_data)
        begin
            stage_byte_reg    <= in_byte;
            stage_literal_reg <= !in_byte[7];
            stage_bad_reg     <= in_byte[7]
                && ({1'b0, in_byte[TABLE_AW-1:0]} >= codes_loaded_reg);
        end
    end

    // A bad code carries a zero symbol; a literal carries the byte itself.
    always_comb
    begin
        push_item.literal      = stage_literal_reg;
        push_item.bad          = stage_bad_reg;
        push_item.length_index = rd_li_reg;
        if (stage_literal_reg)
        begin
            push_item.symbol = stage_byte_reg;
        end
        else if (stage_bad_reg)
        begin
            push_item.symbol = '0;
        end
        else
        begin
            push_item.symbol = rd_symbol_reg;
        end
    end

    assign push_valid = stage_valid_reg;

endmodule

// File: rtl/fbrc_queue.sv
// Short queue of classified words between the front and the back.
module fbrc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  fbrc_pkg::item_t  wr_item,
    output logic             rd_valid,
    input  logic             rd_ready,
    output fbrc_pkg::item_t  rd_item
);
    import fbrc_pkg::*;

    item_t               entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                push;
    logic                pop;

    assign wr_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = entry[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: rtl/fbrc_back.sv
// Back end: turns a classified word into a run and holds it in the output register.
module fbrc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  fbrc_pkg::item_t              item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fbrc_pkg::SYM_W-1:0]   out_symbol,
    output logic [fbrc_pkg::CNT_W-1:0]   repeat_count,
    output logic                         bad_code
);
    import fbrc_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] out_symbol_reg;
    logic [CNT_W-1:0] repeat_count_reg;
    logic             bad_code_reg;
    logic [CNT_W-1:0] count_value;
    logic             load;

    // The output register takes a word when empty or when its word is taken.
    assign item_ready = !out_valid_reg || out_ready;
    assign load       = item_valid && item_ready;

    // Run length: one for a literal, zero for a bad code, else table lookup.
    always_comb
    begin
        if (item.bad)
        begin
            count_value = '0;
        end
        else if (item.literal)
        begin
            count_value = LITERAL_COUNT;
        end
        else
        begin
            count_value = fib_count(item.length_index);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_symbol_reg   <= item.symbol;
            repeat_count_reg <= count_value;
            bad_code_reg     <= item.bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_symbol   = out_symbol_reg;
    assign repeat_count = repeat_count_reg;
    assign bad_code     = bad_code_reg;

endmodule

// File: rtl/fibonacci_run_code_decoder.sv
// Top level of the Fibonacci run-code decoder: front parser, queue and run output stage.
//
//   Channel  Dir  Word contents (lowest bit first)
//   s_*      in   tdata: in_byte[7:0]; tlast: block_last
//   m_*      out  tdata: out_symbol[7:0], repeat_count[20:8], zero pad; tuser: bad_code
//
// One compressed byte is taken per cycle while s_tready is high; header bytes
// give no output word. A data byte moves through the table read stage, the queue
// and the output register in that order before it can leave on m_tdata.
// Reset clears the parser, the queue and the output valid; the code table
// needs no clearing since only entries loaded by the current header are read.
// A stall on m_tready fills the output register, the two-word queue and the
// table read stage before s_tready drops.
module fibonacci_run_code_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_symbol[7:0], repeat_count[20:8], zero [23:21]
    output logic        m_tuser    // bad_code
);
    import fbrc_pkg::*;

    logic             fq_valid;
    logic             fq_ready;
    item_t            fq_item;
    logic             qb_valid;
    logic             qb_ready;
    item_t            qb_item;
    logic [SYM_W-1:0] out_symbol;
    logic [CNT_W-1:0] repeat_count;
    logic             bad_code;

    // Parser and code table.
    fbrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .block_last (s_tlast),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item)
    );

    // Decoupling queue.
    fbrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    // Run count and output register.
    fbrc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (qb_valid),
        .item_ready   (qb_ready),
        .item         (qb_item),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_symbol   (out_symbol),
        .repeat_count (repeat_count),
        .bad_code     (bad_code)
    );

    assign m_tdata = {3'b000, repeat_count, out_symbol};
    assign m_tuser = bad_code;

    // A bad code always reports a zero symbol and a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[20:0] == 21'd0))
    else $error("bad code word carries a nonzero symbol or count");

    // A good word never has a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[20:8] != 13'd0))
    else $error("good word with zero repeat count");

    // Counts stay within the Fibonacci table.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20:8] <= 13'd6765))
    else $error("repeat count beyond table range");

endmodule

// File: bench/tb.sv
// Self-checking testbench for the Fibonacci run-code decoder.
`timescale 1ns / 1ps

module tb;

    import fbrc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_TARGET = 1575;
    localparam int CALM_TAIL = 120;
    localparam int PRINT_CAP = 40;

    // One compressed byte waiting to go out, with a flag that holds it back
    // until every outstanding run has been seen.
    typedef struct packed {
        logic       drain;
        logic       last;
        logic [7:0] val;
    } comp_byte_t;

    // One decoded run as the block should report it.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [CNT_W-1:0] reps;
        logic             bad;
    } run_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // in_byte[7:0]
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // out_symbol[7:0], repeat_count[20:8], zero pad
    logic        m_tuser;            // bad_code

    comp_byte_t comp_bytes[$];
    run_t       runs_due[$];

    int unsigned errors = 0;
    int unsigned bytes_taken = 0;
    int unsigned cycles = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          blk_no = 0;

    // Decoder mirror: header parser state and code table.
    phase_t           dec_phase;
    logic [7:0]       dec_codes_total;
    logic [7:0]       dec_codes_done;
    logic [SYM_W-1:0] sym_tab [TABLE_DEPTH];
    logic [LI_W-1:0]  len_tab [TABLE_DEPTH];

    fibonacci_run_code_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Repeat count for a length index, built up by summing the sequence.
    function automatic logic [CNT_W-1:0] fib_run(input int unsigned idx);
        int unsigned a;
        int unsigned b;
        int unsigned t;
        a = 1;
        b = 1;
        for (int unsigned i = 2; i <= idx; i++)
        begin
            t = a + b;
            a = b;
            b = t;
        end
        return CNT_W'(b);
    endfunction

    // Idle rate moves through calm and busy stretches; none near the end.
    function automatic int idle_rate();
        if (comp_bytes.size() < CALM_TAIL)
            return 0;
        case ((bytes_taken / 180) % 3)
            0:       return 0;
            1:       return 8;
            default: return 30;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Advance the decoder mirror by one accepted byte and queue any run it yields.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [7:0]          li;
        logic [TABLE_AW-1:0] slot;
        logic [TABLE_AW-1:0] code;
        run_t                r;
        slot = dec_codes_done[TABLE_AW-1:0];
        code = b[TABLE_AW-1:0];
        case (dec_phase)
            PH_COUNT:
            begin
                dec_codes_total = (b > CODE_COUNT_MAX) ? CODE_COUNT_MAX : b;
                dec_codes_done = 8'd0;
                dec_phase = (dec_codes_total == 8'd0) ? PH_DATA : PH_SYMBOL;
            end
            PH_SYMBOL:
            begin
                sym_tab[slot] = b;
                dec_phase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                li = (b > LI_MAX_BYTE) ? LI_MAX_BYTE : b;
                len_tab[slot] = li[LI_W-1:0];
                dec_codes_done = dec_codes_done + 8'd1;
                dec_phase = (dec_codes_done >= dec_codes_total) ? PH_DATA : PH_SYMBOL;
            end
            default:
            begin
                if (!b[7])
                begin
                    r.sym = b;
                    r.reps = LITERAL_COUNT;
                    r.bad = 1'b0;
                end
                else if ({1'b0, code} < dec_codes_done)
                begin
                    r.sym = sym_tab[code];
                    r.reps = fib_run(len_tab[code]);
                    r.bad = 1'b0;
                end
                else
                begin
                    r.sym = '0;
                    r.reps = '0;
                    r.bad = 1'b1;
                end
                runs_due.push_back(r);
            end
        endcase
        if (last)
            dec_phase = PH_COUNT;
    endtask

    task automatic push_byte(input logic [7:0] val, input logic last,
                             input logic drain = 1'b0);
        comp_byte_t c;
        c.val = val;
        c.last = last;
        c.drain = drain;
        comp_bytes.push_back(c);
    endtask

    // One random block: mostly well-formed headers with data that uses the
    // loaded codes, some cut-off headers and some noise.
    task automatic gen_block();
        int       kind;
        int       eff;
        int       n_data;
        int       cut;
        int       pick;
        int       len;
        logic     hold;
        logic [7:0] cnt_byte;
        logic [7:0] hdr [$];
        kind = $urandom_range(0, 99);
        hold = (blk_no == 0 || blk_no == 35);
        blk_no++;
        if (kind < 8)
        begin
            // Noise: random bytes with random block ends, closed by a block end.
            n_data = $urandom_range(1, 12);
            for (int i = 0; i < n_data; i++)
                push_byte(8'($urandom), ($urandom_range(0, 4) == 0) || i == n_data - 1,
                          hold && i == 0);
            return;
        end
        pick = $urandom_range(0, 199);
        if (blk_no == 12 || pick == 0)
            cnt_byte = 8'($urandom_range(129, 255));
        else if (blk_no == 30 || pick == 1)
            cnt_byte = 8'd128;
        else if (pick < 10)
            cnt_byte = 8'd0;
        else
            cnt_byte = 8'($urandom_range(1, 10));
        eff = (cnt_byte > 8'd128) ? 128 : int'(cnt_byte);
        hdr.push_back(cnt_byte);
        for (int k = 0; k < eff; k++)
        begin
            hdr.push_back(8'($urandom));
            if ($urandom_range(0, 9) == 0)
                hdr.push_back(8'($urandom_range(20, 255)));
            else
                hdr.push_back(8'($urandom_range(0, 19)));
        end
        // Header cut short by a block end.
        if (kind < 18)
        begin
            cut = $urandom_range(0, hdr.size() - 1);
            for (int i = 0; i <= cut; i++)
                push_byte(hdr[i], i == cut, hold && i == 0);
            return;
        end
        len = hdr.size();
        for (int i = 0; i < len; i++)
            push_byte(hdr[i], 1'b0, hold && i == 0);
        n_data = (eff > 10) ? $urandom_range(20, 60) : $urandom_range(1, 16);
        for (int i = 0; i < n_data; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60 && eff > 0)
                cnt_byte = 8'h80 | 8'($urandom_range(0, eff - 1));
            else if (pick < 85)
                cnt_byte = 8'($urandom_range(0, 127));
            else
                cnt_byte = 8'($urandom_range(128, 255));
            push_byte(cnt_byte, i == n_data - 1, hold && eff == 0 && i == 0);
        end
    endtask

    // Driver: presents queued bytes, holds a byte until taken, idles in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        comp_byte_t c;
        logic       nv;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tlast <= 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            nv = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if ($urandom_range(0, 99) < idle_rate())
                send_gap = $urandom_range(0, 10);
            else if (comp_bytes.size() > 0)
            begin
                c = comp_bytes[0];
                // A held byte waits until no byte is in flight and all runs are in.
                if (!c.drain || (!s_tvalid && runs_due.size() == 0))
                begin
                    void'(comp_bytes.pop_front());
                    s_tdata <= c.val;
                    s_tlast <= c.last;
                    nv = 1'b1;
                end
            end
            s_tvalid <= nv;
        end
    end

    // Monitor: mirrors accepted bytes, checks each run word, stalls the output.
    always @(posedge clk or negedge rst_n)
    begin
        run_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            dec_phase = PH_COUNT;
            dec_codes_total = 8'd0;
            dec_codes_done = 8'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (runs_due.size() == 0)
                    flag_mismatch("unexpected word, symbol", m_tdata[7:0], 0);
                else
                begin
                    want = runs_due.pop_front();
                    if (m_tdata[7:0] !== want.sym)
                        flag_mismatch("out_symbol", m_tdata[7:0], want.sym);
                    if (m_tdata[20:8] !== want.reps)
                        flag_mismatch("repeat_count", m_tdata[20:8], want.reps);
                    if (m_tuser !== want.bad)
                        flag_mismatch("bad_code", m_tuser, want.bad);
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_rate())
            begin
                recv_stall = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        // Three codes with extreme symbols and a clamped length index, then
        // literals at both ends, every loaded code and two unloaded codes.
        push_byte(8'd3, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'd19, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'd200, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h81, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'h83, 1'b0);
        push_byte(8'hFF, 1'b1);
        // Zero codes: data follows the count at once; old entries are unloaded.
        push_byte(8'd0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h55, 1'b1);
        // Oversized count, with the block ending after the first pair.
        push_byte(8'hFF, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'd5, 1'b1);
        // Block that ends on its count byte.
        push_byte(8'd2, 1'b1);
        // Block that ends on a symbol byte whose length never comes.
        push_byte(8'd2, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'd1, 1'b0);
        push_byte(8'h56, 1'b1);
        while (comp_bytes.size() < RANDOM_TARGET)
            gen_block();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (comp_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (runs_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (runs_due.size() != 0)
            flag_mismatch("runs still outstanding", 0, runs_due.size());
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
